// ===== design/fpd_pkg.sv =====
// shared types and constants of the flight phase detector
package fpd_pkg;

   localparam int VEL_W       = 24;
   localparam int TIME_W      = 32;
   localparam int CNT_W       = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   // register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_START_VEL  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STOP_VEL   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SMOOTH_END = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRANS_CNT  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_APOGEE_CNT = 3'd4;

   typedef enum logic [2:0] {
      STG_THRUST    = 3'd0,
      STG_TSTART    = 3'd1,
      STG_SONIC     = 3'd2,
      STG_TSTOP     = 3'd3,
      STG_SMOOTH    = 3'd4,
      STG_CRUISE    = 3'd5,
      STG_APOGEE    = 3'd6,
      STG_FALL      = 3'd7
   } stage_type;

   typedef struct packed {
      logic signed [VEL_W-1:0] start_vel;
      logic signed [VEL_W-1:0] stop_vel;
      logic [TIME_W-1:0]       smooth_end;
      logic [CNT_W-1:0]        trans_cnt;
      logic [CNT_W-1:0]        apogee_cnt;
   } cfg_type;

   typedef struct packed {
      stage_type         stage;
      logic [CNT_W-1:0]  start_cnt;
      logic [CNT_W-1:0]  end_cnt;
      logic [CNT_W-1:0]  smooth_cnt;
      logic [CNT_W-1:0]  apogee_cnt;
      logic [TIME_W-1:0] start_time;
      logic [TIME_W-1:0] end_time;
      logic [TIME_W-1:0] peak_time;
   } track_type;

endpackage

// ===== design/fpd_if.sv =====
// sample and result channel interfaces of the flight phase detector
interface fpd_req_if import fpd_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [VEL_W-1:0] velocity;
   logic [TIME_W-1:0]       sample_time;

   modport source (output valid, velocity, sample_time, input ready);
   modport sink (input valid, velocity, sample_time, output ready);
endinterface

interface fpd_rsp_if import fpd_pkg::*; ();
   logic              valid;
   logic              ready;
   stage_type         stage;
   logic [TIME_W-1:0] transonic_start_time;
   logic [TIME_W-1:0] transonic_end_time;
   logic [TIME_W-1:0] peak_time;

   modport source (output valid, stage, transonic_start_time, transonic_end_time,
                   peak_time, input ready);
   modport sink (input valid, stage, transonic_start_time, transonic_end_time,
                 peak_time, output ready);
endinterface

// ===== design/fpd_csr.sv =====
// configuration registers of the flight phase detector
module fpd_csr import fpd_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data,
   output cfg_type                cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_vel  <= '0;
         cfg_ff.stop_vel   <= '0;
         cfg_ff.smooth_end <= '0;
         cfg_ff.trans_cnt  <= CNT_W'(1);
         cfg_ff.apogee_cnt <= CNT_W'(1);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_START_VEL:  cfg_ff.start_vel  <= csr_wr_data[VEL_W-1:0];
            CSR_STOP_VEL:   cfg_ff.stop_vel   <= csr_wr_data[VEL_W-1:0];
            CSR_SMOOTH_END: cfg_ff.smooth_end <= csr_wr_data[TIME_W-1:0];
            CSR_TRANS_CNT:  cfg_ff.trans_cnt  <= csr_wr_data[CNT_W-1:0];
            CSR_APOGEE_CNT: cfg_ff.apogee_cnt <= csr_wr_data[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== design/fpd_step.sv =====
// next stage, counters and captured times for one sample
module fpd_step import fpd_pkg::*; (
   input  cfg_type                 cfg,
   input  track_type               cur,
   input  logic signed [VEL_W-1:0] velocity,
   input  logic [TIME_W-1:0]       sample_time,
   output track_type               nxt
);

   // saturating increment
   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
      sat_inc = (c == CNT_MAX) ? c : c + CNT_W'(1);
   endfunction

   logic [CNT_W-1:0] start_inc, end_inc, smooth_inc, apogee_inc;
   logic             start_q, end_q, smooth_q, apogee_q;

   assign start_inc  = sat_inc(cur.start_cnt);
   assign end_inc    = sat_inc(cur.end_cnt);
   assign smooth_inc = sat_inc(cur.smooth_cnt);
   assign apogee_inc = sat_inc(cur.apogee_cnt);

   assign start_q  = velocity > cfg.start_vel;
   assign end_q    = velocity < cfg.stop_vel;
   assign smooth_q = sample_time > cfg.smooth_end;
   assign apogee_q = velocity[VEL_W-1] || (velocity == '0);

   always_comb begin
      nxt = cur;
      unique case (cur.stage)
         STG_THRUST: begin
            if (start_q) begin
               nxt.start_cnt = start_inc;
               if (start_inc >= cfg.trans_cnt) begin
                  nxt.start_time = sample_time;
                  nxt.stage      = STG_TSTART;
               end
            end
         end
         STG_TSTART:    nxt.stage = STG_SONIC;
         STG_SONIC: begin
            if (end_q) begin
               nxt.end_cnt = end_inc;
               if (end_inc >= cfg.trans_cnt) begin
                  nxt.end_time = sample_time;
                  nxt.stage    = STG_TSTOP;
               end
            end
         end
         STG_TSTOP:     nxt.stage = STG_SMOOTH;
         STG_SMOOTH: begin
            if (smooth_q) begin
               nxt.smooth_cnt = smooth_inc;
               if (smooth_inc >= cfg.trans_cnt) begin
                  nxt.stage = STG_CRUISE;
               end
            end
         end
         STG_CRUISE: begin
            if (apogee_q) begin
               nxt.apogee_cnt = apogee_inc;
               if (apogee_inc >= cfg.apogee_cnt) begin
                  nxt.peak_time = sample_time;
                  nxt.stage     = STG_APOGEE;
               end
            end
         end
         STG_APOGEE:    nxt.stage = STG_FALL;
         default: ;
      endcase
   end

endmodule

// ===== design/flight_phase_detector_core.sv =====
// top level of the flight phase detector
// Flight phase detector: each velocity sample (signed Q16.8 m/s) with its ms timestamp
// moves a fixed sequence of eight flight stages forward and produces exactly one result
// item carrying the stage after that sample and the three captured event times. An item
// waits in the input register, then moves to the output register that drives the result;
// one item is taken every cycle when the result side is ready, as the stage update is
// combinational and reads the state written by the previous item. A stalled result holds;
// back-pressure reaches the input only when both registers are full. Configuration is
// written by the user via the csr_ port only while idle; the block does not enforce it.
module flight_phase_detector_core import fpd_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   fpd_req_if.sink                req_bus,
   fpd_rsp_if.source              rsp_bus,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data
);

   cfg_type   cfg;
   track_type track_ff, track_in;

   // input register
   logic                    s1_valid_ff;
   logic signed [VEL_W-1:0] s1_vel_ff;
   logic [TIME_W-1:0]       s1_time_ff;

   // output register
   logic      out_valid_ff;
   track_type out_ff;

   logic advance;

   fpd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   fpd_step u_step (
      .cfg         (cfg),
      .cur         (track_ff),
      .velocity    (s1_vel_ff),
      .sample_time (s1_time_ff),
      .nxt         (track_in)
   );

   // item moves to the output register when that register is empty or being drained
   assign advance       = s1_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         s1_valid_ff <= req_bus.valid;
      end
   end

   // payload of the input register, loaded on accept
   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         s1_vel_ff  <= req_bus.velocity;
         s1_time_ff <= req_bus.sample_time;
      end
   end

   // flight state: stage, qualifying counters, captured times
   always_ff @(posedge clock) begin
      if (reset) begin
         track_ff <= '0;
      end else if (advance) begin
         track_ff <= track_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // result payload, held while stalled
   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= track_in;
      end
   end

   assign rsp_bus.valid                = out_valid_ff;
   assign rsp_bus.stage                = out_ff.stage;
   assign rsp_bus.transonic_start_time = out_ff.start_time;
   assign rsp_bus.transonic_end_time   = out_ff.end_time;
   assign rsp_bus.peak_time            = out_ff.peak_time;

endmodule

// ===== design/fpd_checker.sv =====
// port-level checks of the flight phase detector and their bind
module fpd_checker import fpd_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input stage_type         stage,
   input logic [TIME_W-1:0] start_time,
   input logic [TIME_W-1:0] end_time,
   input logic [TIME_W-1:0] peak_time
);

   logic              rsp_take;
   logic              seen_ff;
   stage_type         last_stage_ff;
   logic [TIME_W-1:0] last_apogee_ff;

   assign rsp_take = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff        <= 1'b0;
         last_stage_ff  <= STG_THRUST;
         last_apogee_ff <= '0;
      end else if (rsp_take) begin
         seen_ff        <= 1'b1;
         last_stage_ff  <= stage;
         last_apogee_ff <= peak_time;
      end
   end

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(stage) && $stable(start_time)
         && $stable(end_time) && $stable(peak_time))
      else $error("result changed while stalled");

   // stages never go back
   a_stage_order: assert property (@(posedge clock) disable iff (reset)
      rsp_take && seen_ff |-> stage >= last_stage_ff)
      else $error("stage moved backwards");

   // descent is final and keeps the apogee time
   a_descent_final: assert property (@(posedge clock) disable iff (reset)
      rsp_take && seen_ff && last_stage_ff == STG_FALL |->
         stage == STG_FALL && peak_time == last_apogee_ff)
      else $error("descent left or apogee time changed");

   // no event time is captured while still thrusting
   a_thrust_times: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && stage == STG_THRUST |->
         start_time == '0 && end_time == '0 && peak_time == '0)
      else $error("event time set during thrust");

endmodule

bind flight_phase_detector_core fpd_checker u_fpd_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .stage       (rsp_bus.stage),
   .start_time  (rsp_bus.transonic_start_time),
   .end_time    (rsp_bus.transonic_end_time),
   .peak_time   (rsp_bus.peak_time)
);
